FILE: design/hcr_pkg.sv
`default_nettype none
package hcr_pkg;

   localparam int MaxWidth  = 1024;
   localparam int MaxHeight = 1024;
   localparam int ColW      = $clog2(MaxWidth);
   localparam int RowW      = $clog2(MaxHeight);
   localparam int DimW      = 11;
   localparam int KW        = 16;
   localparam int StoreAw   = 2 + ColW;
   localparam int MulW      = 35;
   localparam int ProdW     = 2 * MulW;
   localparam int RespW     = 50;
   localparam int CsrAw     = 4;
   localparam int CsrDw     = 32;

   localparam logic [DimW-1:0] MinDim      = DimW'(5);
   localparam logic [DimW-1:0] MaxWidthDim  = DimW'(MaxWidth);
   localparam logic [DimW-1:0] MaxHeightDim = DimW'(MaxHeight);
   localparam logic [DimW-1:0] ResetWidth  = DimW'(640);
   localparam logic [DimW-1:0] ResetHeight = DimW'(480);
   localparam logic [KW-1:0]   ResetK      = KW'(2621);

   typedef logic [4:0][4:0][7:0] window_type;
   typedef logic signed [10:0]   grad_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_SHIFT, ST_GRAD, ST_MUL, ST_ACC, ST_SUM, ST_FIN
   } state_type;

   typedef enum logic [2:0] {
      OP_GXX, OP_GYY, OP_GXY, OP_TT, OP_DET, OP_SXY2, OP_KHI, OP_KLO
   } op_type;

   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_K      = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic               wr_en;
      logic [StoreAw-1:0] wr_addr;
      logic [7:0]         wr_data;
      logic [StoreAw-1:0] rd_addr;
   } store_ctl_type;

endpackage
`default_nettype wire

FILE: design/hcr_if.sv
`default_nettype none
interface hcr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel;
   logic       frame_start;
   modport source(output valid, pixel, frame_start, input ready);
   modport sink(input valid, pixel, frame_start, output ready);
endinterface

interface hcr_rsp_if;
   logic        valid;
   logic        ready;
   logic [49:0] response;
   logic [9:0]  centre_x;
   logic [9:0]  centre_y;
   logic        last;
   modport source(output valid, response, centre_x, centre_y, last, input ready);
   modport sink(input valid, response, centre_x, centre_y, last, output ready);
endinterface
`default_nettype wire

FILE: design/hcr_line_store.sv
`default_nettype none
module hcr_line_store
   import hcr_pkg::*;
(
   input  wire logic          clock,
   input  wire store_ctl_type ctl,
   output logic [7:0]         rd_data
);

   logic [7:0] mem [2**StoreAw];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      rd_data_ff <= mem[ctl.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: design/hcr_grad.sv
`default_nettype none
module hcr_grad
   import hcr_pkg::*;
(
   input  wire window_type win,
   input  wire logic [1:0] pos_r,
   input  wire logic [1:0] pos_c,
   output grad_type        gx,
   output grad_type        gy
);

   logic [2:0] ri [3];
   logic [2:0] ci [3];
   grad_type   p [3][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ri[i] = {1'b0, pos_r} + 3'(i) - 3'd1;
         ci[i] = {1'b0, pos_c} + 3'(i) - 3'd1;
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            p[i][j] = signed'({3'b000, win[ri[i]][ci[j]]});
         end
      end
      gx = p[0][2] - p[0][0] + ((p[1][2] - p[1][0]) <<< 1) + p[2][2] - p[2][0];
      gy = p[2][0] - p[0][0] + ((p[2][1] - p[0][1]) <<< 1) + p[2][2] - p[0][2];
   end

endmodule
`default_nettype wire

FILE: design/hcr_mul.sv
`default_nettype none
module hcr_mul
   import hcr_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic signed [MulW-1:0]  a,
   input  wire logic signed [MulW-1:0]  b,
   output logic signed [ProdW-1:0]      prod
);

   logic signed [ProdW-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= a * b;
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

FILE: design/harris_corner_response.sv
// Non-scoring pixel: after accept, 4 line store reads and a window shift, then ready again.
// Scoring pixel: the one shared 35x35 multiplier forms 32 products, each an issue step and
// an accumulate step; the result lands in an output register, valid from the cycle in which
// ready returns.
// One pixel at a time; a scoring pixel holds in its last cycle while the previous result waits.
// Synchronous active-high reset clears column/row counters, sequencer and output valid, and
// presets geometry/k registers; line store and window contents are undefined until written.
`default_nettype none
module harris_corner_response
   import hcr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   hcr_req_if.sink                 req_ch,
   hcr_rsp_if.source               rsp_ch,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [CsrAw-1:0]   csr_paddr,
   input  wire logic [CsrDw-1:0]   csr_pwdata,
   output logic [CsrDw-1:0]        csr_prdata,
   output logic                    csr_pready
);

   state_type state_ff, state_in;
   op_type    op_ff;

   logic [DimW-1:0] width_ff, height_ff, w_eff, h_eff;
   logic [KW-1:0]   k_ff;
   csr_index_type   csr_idx;

   logic [ColW-1:0] col_count_ff;
   logic [RowW-1:0] row_count_ff;
   logic [ColW-1:0] cur_x_ff;
   logic [RowW-1:0] cur_y_ff;
   logic [7:0]      pixel_ff;
   logic [1:0]      rd_cnt_ff;
   logic [7:0]      col_ff [3];
   window_type      win_ff;
   logic [1:0]      pos_r_ff, pos_c_ff;
   logic            score;

   grad_type        gx, gy, gx_ff, gy_ff;
   logic [23:0]     sxx_ff, syy_ff;
   logic [24:0]     sxy_ff;
   logic [24:0]     t_ff;
   logic [49:0]     t2_ff;
   logic [48:0]     det_ff;
   logic [49:0]     kt_ff;
   logic            last_ff;

   logic signed [MulW-1:0]  mul_a, mul_b;
   logic signed [ProdW-1:0] prod;

   store_ctl_type  store_ctl;
   logic [7:0]     rd_data;
   logic [1:0]     rd_row;

   logic [DimW-1:0] x_next, y_next;
   logic            accept, csr_wr, out_load;

   logic            rsp_valid_ff;
   logic [RespW-1:0] resp_ff;
   logic [ColW-1:0] rsp_x_ff;
   logic [RowW-1:0] rsp_y_ff;
   logic            rsp_last_ff;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_index_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_idx)
         REG_WIDTH:  csr_prdata = CsrDw'(width_ff);
         REG_HEIGHT: csr_prdata = CsrDw'(height_ff);
         REG_K:      csr_prdata = CsrDw'(k_ff);
         default:    csr_prdata = '0;
      endcase
   end

   always_comb begin
      w_eff = (width_ff < MinDim) ? MinDim :
              ((width_ff > MaxWidthDim) ? MaxWidthDim : width_ff);
      h_eff = (height_ff < MinDim) ? MinDim :
              ((height_ff > MaxHeightDim) ? MaxHeightDim : height_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= ResetWidth;
         height_ff <= ResetHeight;
         k_ff      <= ResetK;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_WIDTH:  width_ff  <= csr_pwdata[DimW-1:0];
            REG_HEIGHT: height_ff <= csr_pwdata[DimW-1:0];
            REG_K:      k_ff      <= csr_pwdata[KW-1:0];
            default:    ;
         endcase
      end
   end

   assign accept = req_ch.valid && req_ch.ready;
   assign score  = (cur_x_ff >= ColW'(4)) && (cur_y_ff >= RowW'(4));
   assign out_load = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_ch.valid) state_in = ST_READ;
         ST_READ:  if (rd_cnt_ff == 2'd3) state_in = ST_SHIFT;
         ST_SHIFT: state_in = score ? ST_GRAD : ST_IDLE;
         ST_GRAD:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_ACC;
         ST_ACC: begin
            case (op_ff)
               OP_GXY:  state_in = (pos_r_ff == 2'd3 && pos_c_ff == 2'd3) ? ST_SUM : ST_GRAD;
               OP_KLO:  state_in = ST_FIN;
               default: state_in = ST_MUL;
            endcase
         end
         ST_SUM:   state_in = ST_MUL;
         ST_FIN:   if (out_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready = (state_ff == ST_IDLE);
      rd_row = cur_y_ff[1:0] + rd_cnt_ff;
      store_ctl.rd_addr = {rd_row, cur_x_ff};
      store_ctl.wr_en   = (state_ff == ST_SHIFT);
      store_ctl.wr_addr = {cur_y_ff[1:0], cur_x_ff};
      store_ctl.wr_data = pixel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign x_next = DimW'(cur_x_ff) + DimW'(1);
   assign y_next = DimW'(cur_y_ff) + DimW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else if (state_ff == ST_SHIFT) begin
         if (x_next >= w_eff) begin
            col_count_ff <= '0;
            row_count_ff <= (y_next >= h_eff) ? '0 : y_next[RowW-1:0];
         end else begin
            col_count_ff <= x_next[ColW-1:0];
            row_count_ff <= cur_y_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_x_ff  <= req_ch.frame_start ? '0 : col_count_ff;
         cur_y_ff  <= req_ch.frame_start ? '0 : row_count_ff;
         pixel_ff  <= req_ch.pixel;
         rd_cnt_ff <= '0;
      end
      if (state_ff == ST_READ) begin
         rd_cnt_ff <= rd_cnt_ff + 2'd1;
         if (rd_cnt_ff != 2'd0) begin
            col_ff[rd_cnt_ff - 2'd1] <= rd_data;
         end
      end
      if (state_ff == ST_SHIFT) begin
         for (int r = 0; r < 5; r++) begin
            for (int c = 0; c < 4; c++) begin
               win_ff[r][c] <= win_ff[r][c+1];
            end
         end
         for (int r = 0; r < 3; r++) begin
            win_ff[r][4] <= col_ff[r];
         end
         win_ff[3][4] <= rd_data;
         win_ff[4][4] <= pixel_ff;
         pos_r_ff <= 2'd1;
         pos_c_ff <= 2'd1;
         op_ff    <= OP_GXX;
         sxx_ff   <= '0;
         syy_ff   <= '0;
         sxy_ff   <= '0;
         last_ff  <= (DimW'(cur_x_ff) == w_eff - DimW'(1)) &&
                     (DimW'(cur_y_ff) == h_eff - DimW'(1));
      end
      if (state_ff == ST_GRAD) begin
         gx_ff <= gx;
         gy_ff <= gy;
         op_ff <= OP_GXX;
      end
      if (state_ff == ST_SUM) begin
         t_ff  <= 25'(sxx_ff) + 25'(syy_ff);
         op_ff <= OP_TT;
      end
      if (state_ff == ST_ACC) begin
         case (op_ff)
            OP_GXX:  begin
               sxx_ff <= sxx_ff + prod[23:0];
               op_ff  <= OP_GYY;
            end
            OP_GYY:  begin
               syy_ff <= syy_ff + prod[23:0];
               op_ff  <= OP_GXY;
            end
            OP_GXY:  begin
               sxy_ff <= sxy_ff + prod[24:0];
               if (pos_c_ff == 2'd3) begin
                  pos_c_ff <= 2'd1;
                  pos_r_ff <= pos_r_ff + 2'd1;
               end else begin
                  pos_c_ff <= pos_c_ff + 2'd1;
               end
            end
            OP_TT:   begin
               t2_ff <= prod[49:0];
               op_ff <= OP_DET;
            end
            OP_DET:  begin
               det_ff <= prod[48:0];
               op_ff  <= OP_SXY2;
            end
            OP_SXY2: begin
               det_ff <= det_ff - prod[48:0];
               op_ff  <= OP_KHI;
            end
            OP_KHI:  begin
               kt_ff <= prod[49:0];
               op_ff <= OP_KLO;
            end
            OP_KLO:  kt_ff <= kt_ff + 50'(prod[31:16]);
            default: ;
         endcase
      end
   end

   always_comb begin
      case (op_ff)
         OP_GXX:  begin
            mul_a = MulW'(gx_ff);
            mul_b = MulW'(gx_ff);
         end
         OP_GYY:  begin
            mul_a = MulW'(gy_ff);
            mul_b = MulW'(gy_ff);
         end
         OP_GXY:  begin
            mul_a = MulW'(gx_ff);
            mul_b = MulW'(gy_ff);
         end
         OP_TT:   begin
            mul_a = signed'(MulW'(t_ff));
            mul_b = signed'(MulW'(t_ff));
         end
         OP_DET:  begin
            mul_a = signed'(MulW'(sxx_ff));
            mul_b = signed'(MulW'(syy_ff));
         end
         OP_SXY2: begin
            mul_a = MulW'(signed'(sxy_ff));
            mul_b = MulW'(signed'(sxy_ff));
         end
         OP_KHI:  begin
            mul_a = signed'(MulW'(t2_ff[49:16]));
            mul_b = signed'(MulW'(k_ff));
         end
         OP_KLO:  begin
            mul_a = signed'(MulW'(t2_ff[15:0]));
            mul_b = signed'(MulW'(k_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         resp_ff     <= {det_ff[48], det_ff} - kt_ff;
         rsp_x_ff    <= cur_x_ff - ColW'(2);
         rsp_y_ff    <= cur_y_ff - RowW'(2);
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.response = resp_ff;
   assign rsp_ch.centre_x = rsp_x_ff;
   assign rsp_ch.centre_y = rsp_y_ff;
   assign rsp_ch.last     = rsp_last_ff;

   hcr_line_store u_store (
      .clock   (clock),
      .ctl     (store_ctl),
      .rd_data (rd_data)
   );

   hcr_grad u_grad (
      .win   (win_ff),
      .pos_r (pos_r_ff),
      .pos_c (pos_c_ff),
      .gx    (gx),
      .gy    (gy)
   );

   hcr_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

endmodule
`default_nettype wire
